[hdl/software_timer_bank_core_defines.svh]
// ---------------------------------------------------------------------------
// Software timer bank assertion macros
// Shared concurrent assertion forms, clocked on clk.
// ---------------------------------------------------------------------------
`ifndef SOFTWARE_TIMER_BANK_CORE_DEFINES_SVH
`define SOFTWARE_TIMER_BANK_CORE_DEFINES_SVH

// Checked only outside reset.
`define STB_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Checked at every edge, reset included.
`define STB_ASSERT_ANY(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hdl/stb_pkg.sv]
// ---------------------------------------------------------------------------
// Software timer bank package
// Sizes, codes and record types shared by the timer bank modules.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package stb_pkg;

  localparam int NUM_SLOTS    = 16;
  localparam int BANK_CAP     = 16;
  localparam int ACTIVE_SLOTS = (NUM_SLOTS < BANK_CAP) ? NUM_SLOTS : BANK_CAP;
  localparam int IDX_W        = (ACTIVE_SLOTS > 1) ? $clog2(ACTIVE_SLOTS) : 1;
  localparam int CNT_W        = IDX_W + 1;
  localparam int SLOT_W       = 4;
  localparam int WORD_W       = 32;
  localparam int IN_DATA_W    = 72;
  localparam int IN_USER_W    = 3;
  localparam int OUT_DATA_W   = 80;
  localparam int OUT_USER_W   = 2;

  typedef enum logic [2:0] {
    OP_TICK    = 3'd0,
    OP_SETUP   = 3'd1,
    OP_START   = 3'd2,
    OP_STOP    = 3'd3,
    OP_RESUME  = 3'd4,
    OP_DESTROY = 3'd5,
    OP_QUERY   = 3'd6
  } op_e;

  typedef enum logic [2:0] {
    ST_UNUSED    = 3'd0,
    ST_CREATED   = 3'd1,
    ST_STARTED   = 3'd2,
    ST_STOPPED   = 3'd3,
    ST_DESTROYED = 3'd4
  } slot_state_e;

  typedef enum logic [1:0] {
    EV_EXPIRY = 2'd0,
    EV_QUERY  = 2'd1,
    EV_ACK    = 2'd2
  } ev_kind_e;

  // One timer slot as it travels round the ring.
  typedef struct packed {
    logic [WORD_W-1:0] remaining;
    logic [WORD_W-1:0] first_delay;
    logic [WORD_W-1:0] period;
    slot_state_e       state;
    logic              strict;
  } rec_t;

  typedef struct packed {
    op_e               op;
    logic [SLOT_W-1:0] slot;
    logic [WORD_W-1:0] first_delay;
    logic [WORD_W-1:0] period;
    logic              strict;
  } cmd_t;

  typedef struct packed {
    ev_kind_e          kind;
    logic [SLOT_W-1:0] slot;
    logic              accepted;
    slot_state_e       state;
    logic              strict;
    logic [WORD_W-1:0] delay;
    logic [WORD_W-1:0] period;
  } res_t;

endpackage

[hdl/stb_cell.sv]
// ---------------------------------------------------------------------------
// Timer ring cell
// Holds one slot record and passes it to the next cell on every enabled cycle.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module stb_cell (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  stb_pkg::rec_t d,
  output stb_pkg::rec_t q
);
  import stb_pkg::*;

  rec_t rec_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rec_r <= '0;
    end else if (en) begin
      rec_r <= d;
    end
  end

  assign q = rec_r;

endmodule

[hdl/stb_head.sv]
// ---------------------------------------------------------------------------
// Timer ring head
// Applies a tick or a command to the record at the head of the ring and
// forms the result item that it causes.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module stb_head (
  input  stb_pkg::rec_t              rec_i,
  input  stb_pkg::cmd_t              cmd_i,
  input  logic                       tick_i,
  input  logic                       valid_i,
  input  logic [stb_pkg::SLOT_W-1:0] slot_i,
  output stb_pkg::rec_t              rec_o,
  output stb_pkg::res_t              res_o,
  output logic                       emit_o
);
  import stb_pkg::*;

  logic [WORD_W-1:0] dec;
  logic [WORD_W-1:0] reload;
  logic              ok;

  assign dec    = rec_i.remaining - WORD_W'(1);
  assign reload = (rec_i.first_delay != '0) ? rec_i.first_delay : rec_i.period;

  always_comb begin
    rec_o  = rec_i;
    res_o  = '0;
    emit_o = 1'b0;
    ok     = 1'b0;
    if (tick_i) begin
      if (rec_i.state == ST_STARTED && rec_i.remaining != '0) begin
        rec_o.remaining = dec;
        if (dec == '0) begin
          emit_o = 1'b1;
          if (rec_i.period != '0) begin
            rec_o.remaining = rec_i.period;
          end else begin
            rec_o.state = ST_STOPPED;
          end
        end
      end
      res_o.kind     = EV_EXPIRY;
      res_o.slot     = slot_i;
      res_o.accepted = 1'b1;
      res_o.state    = rec_o.state;
      res_o.strict   = rec_i.strict;
    end else if (!valid_i) begin
      // A slot beyond the bank is refused and reports an empty slot.
      res_o.kind = (cmd_i.op == OP_QUERY) ? EV_QUERY : EV_ACK;
      res_o.slot = cmd_i.slot;
    end else begin
      unique case (cmd_i.op)
        OP_SETUP: begin
          rec_o.first_delay = cmd_i.first_delay;
          rec_o.period      = cmd_i.period;
          rec_o.strict      = cmd_i.strict;
          rec_o.remaining   = (cmd_i.first_delay != '0) ? cmd_i.first_delay
                                                        : cmd_i.period;
          rec_o.state       = ST_CREATED;
          ok                = 1'b1;
        end
        OP_START: begin
          if (rec_i.state == ST_CREATED || rec_i.state == ST_STOPPED) begin
            rec_o.remaining = reload;
            rec_o.state     = ST_STARTED;
            ok              = 1'b1;
          end
        end
        OP_STOP: begin
          if (rec_i.state == ST_STARTED) begin
            rec_o.state = ST_STOPPED;
            ok          = 1'b1;
          end
        end
        OP_RESUME: begin
          if (rec_i.state == ST_STOPPED) begin
            rec_o.state = ST_STARTED;
            ok          = 1'b1;
          end
        end
        OP_DESTROY: begin
          if (rec_i.state == ST_STARTED) begin
            rec_o.state = ST_DESTROYED;
            ok          = 1'b1;
          end
        end
        default: begin
        end
      endcase
      res_o.slot   = cmd_i.slot;
      res_o.state  = rec_o.state;
      res_o.strict = rec_o.strict;
      if (cmd_i.op == OP_QUERY) begin
        res_o.kind     = EV_QUERY;
        res_o.accepted = 1'b1;
        res_o.delay    = rec_i.first_delay;
        res_o.period   = rec_i.period;
      end else begin
        res_o.kind     = EV_ACK;
        res_o.accepted = ok;
      end
    end
  end

endmodule

[hdl/software_timer_bank_core.sv]
// ---------------------------------------------------------------------------
// Software timer bank core
// Bank of one-shot and periodic timers held in a rotating ring of slot cells.
// ---------------------------------------------------------------------------
// Commands arrive as items on the in_ stream, with the operation in in_tuser.
// Results leave on the out_ stream, with the event kind in out_tuser and
// tlast on the final result that an input item causes.
// The slot records circulate through a ring of cells, one step per cycle;
// all work is done on the record at the head of the ring.
// A command waits until its slot reaches the head and yields one item; a
// command for a slot beyond the bank does not wait and is refused.
// A tick waits for slot 0 and then walks every slot in ascending order,
// and yields one expiry item per slot that ran out, or none. One expiry is
// held back so that the final one can carry tlast.
// One input item is taken at a time; in_tready is high while the core idles.
// While a result waits in the output register and out_tready is low, the
// ring stops turning, so nothing is lost.
// Reset clears every slot to unused with zero counts and settings.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "software_timer_bank_core_defines.svh"

module software_timer_bank_core (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // slot[3:0], first_delay[35:4], period[67:36], strict_class[68]
  input  logic [stb_pkg::IN_DATA_W-1:0]  in_tdata,
  // operation[2:0]
  input  logic [stb_pkg::IN_USER_W-1:0]  in_tuser,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // slot_out[3:0], accepted[4], state_code[7:5], class_out[8],
  // delay_out[40:9], period_out[72:41]
  output logic [stb_pkg::OUT_DATA_W-1:0] out_tdata,
  // event_kind[1:0]
  output logic [stb_pkg::OUT_USER_W-1:0] out_tuser,
  output logic                           out_tlast
);
  import stb_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMD,
    S_TICK,
    S_FLUSH
  } fsm_t;

  fsm_t             state_r, state_nxt;
  cmd_t             cmd_r, cmd_nxt;
  logic [IDX_W-1:0] head_r, head_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             out_last_r, out_last_nxt;
  res_t             out_res_r, out_res_nxt;
  logic             pend_v_r, pend_v_nxt;
  res_t             pend_res_r, pend_res_nxt;

  rec_t ring_q [ACTIVE_SLOTS];
  rec_t ring_d [ACTIVE_SLOTS];
  rec_t ring_feed;
  rec_t head_rec;
  res_t head_res;
  logic head_emit;

  logic shift_en;
  logic slot_ok;
  logic at_slot;
  logic at_cnt;
  logic proc;

  assign shift_en = !out_valid_r || out_tready;
  assign slot_ok  = (32'(cmd_r.slot) < ACTIVE_SLOTS);
  assign at_slot  = (cmd_r.slot[IDX_W-1:0] == head_r);
  assign at_cnt   = (cnt_r[IDX_W-1:0] == head_r);
  assign proc     = shift_en &&
                    ((state_r == S_CMD && (!slot_ok || at_slot)) ||
                     (state_r == S_TICK && at_cnt));

  stb_head u_head (
    .rec_i   (ring_q[0]),
    .cmd_i   (cmd_r),
    .tick_i  (state_r == S_TICK),
    .valid_i (slot_ok),
    .slot_i  (SLOT_W'(head_r)),
    .rec_o   (head_rec),
    .res_o   (head_res),
    .emit_o  (head_emit)
  );

  // The head record re-enters the ring at its tail, updated when worked on.
  assign ring_feed = proc ? head_rec : ring_q[0];

  for (genvar i = 0; i < ACTIVE_SLOTS; i++) begin : g_ring
    if (i == ACTIVE_SLOTS - 1) begin : g_tail
      assign ring_d[i] = ring_feed;
    end else begin : g_mid
      assign ring_d[i] = ring_q[i+1];
    end
    stb_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (shift_en),
      .d     (ring_d[i]),
      .q     (ring_q[i])
    );
  end

  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    head_nxt      = head_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_last_nxt  = out_last_r;
    out_res_nxt   = out_res_r;
    pend_v_nxt    = pend_v_r;
    pend_res_nxt  = pend_res_r;

    if (shift_en) begin
      head_nxt = (head_r == IDX_W'(ACTIVE_SLOTS - 1)) ? '0 : head_r + IDX_W'(1);
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd_nxt.op          = op_e'(in_tuser);
          cmd_nxt.slot        = in_tdata[3:0];
          cmd_nxt.first_delay = in_tdata[35:4];
          cmd_nxt.period      = in_tdata[67:36];
          cmd_nxt.strict      = in_tdata[68];
          cnt_nxt             = '0;
          state_nxt           = (op_e'(in_tuser) == OP_TICK) ? S_TICK : S_CMD;
        end
      end
      S_CMD: begin
        if (proc) begin
          out_valid_nxt = 1'b1;
          out_last_nxt  = 1'b1;
          out_res_nxt   = head_res;
          state_nxt     = S_IDLE;
        end
      end
      S_TICK: begin
        if (proc) begin
          cnt_nxt = cnt_r + CNT_W'(1);
          if (head_emit) begin
            // A newer expiry exists, so the held one is not the last.
            if (pend_v_r) begin
              out_valid_nxt = 1'b1;
              out_last_nxt  = 1'b0;
              out_res_nxt   = pend_res_r;
            end
            pend_v_nxt   = 1'b1;
            pend_res_nxt = head_res;
          end
          if (cnt_r == CNT_W'(ACTIVE_SLOTS - 1)) begin
            state_nxt = S_FLUSH;
          end
        end
      end
      S_FLUSH: begin
        if (shift_en) begin
          if (pend_v_r) begin
            out_valid_nxt = 1'b1;
            out_last_nxt  = 1'b1;
            out_res_nxt   = pend_res_r;
          end
          pend_v_nxt = 1'b0;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      pend_v_r    <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      pend_v_r    <= pend_v_nxt;
    end
    cmd_r      <= cmd_nxt;
    out_last_r <= out_last_nxt;
    out_res_r  <= out_res_nxt;
    pend_res_r <= pend_res_nxt;
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_res_r.kind;
  assign out_tdata  = {7'd0, out_res_r.period, out_res_r.delay, out_res_r.strict,
                       out_res_r.state, out_res_r.accepted, out_res_r.slot};

  `STB_ASSERT(a_ring_holds_on_stall, out_valid_r && !out_tready |=> $stable(head_r), "ring turned while a result was stalled")
  `STB_ASSERT(a_idle_no_pending, state_r == S_IDLE |-> !pend_v_r, "expiry left pending at idle")
  `STB_ASSERT(a_pending_in_tick, pend_v_r |-> state_r == S_TICK || state_r == S_FLUSH, "expiry held outside a tick")
  `STB_ASSERT(a_cnt_bound, state_r == S_TICK |-> cnt_r < CNT_W'(ACTIVE_SLOTS), "tick walk ran past the bank")
  `STB_ASSERT_ANY(a_reset_clears, !rst_n |=> !out_valid_r && state_r == S_IDLE, "reset did not clear the output")

endmodule
